@@ sv/rdc_pkg.sv @@
package rdc_pkg;

  localparam int VALUE_W   = 31;
  localparam int RADIX_W   = 6;
  localparam int DIGIT_W   = 6;

  localparam int DIGIT_DEPTH_DEF = 32;

  // quotient bits resolved per divider cycle
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = (VALUE_W + DIV_BITS - 1) / DIV_BITS;
  localparam int WORK_W    = DIV_STEPS * DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic load;
    logic run;
  } div_ctrl_t;

  typedef struct packed {
    logic               done;
    logic               quo_zero;
    logic [DIGIT_W-1:0] digit;
  } div_stat_t;

endpackage

@@ sv/rdc_ram.sv @@
module rdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/rdc_divider.sv @@
module rdc_divider import rdc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  div_ctrl_t          ctrl_i,
  input  logic [VALUE_W-1:0] value_i,
  input  logic [RADIX_W-1:0] radix_i,
  output div_stat_t          stat_o
);

  logic [WORK_W-1:0]  work_q, work_d;
  logic [RADIX_W-1:0] rem_q, rem_d;
  logic [RADIX_W-1:0] radix_q;
  logic [STEP_W-1:0]  step_q;
  logic               last_step;

  // dividend bits leave at the top, quotient bits enter at the bottom
  always_comb begin
    logic [RADIX_W:0]   trial;
    logic [RADIX_W-1:0] rem;
    logic [WORK_W-1:0]  w;
    rem = rem_q;
    w   = work_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {rem, w[WORK_W-1]};
      w     = {w[WORK_W-2:0], 1'b0};
      if (trial >= {1'b0, radix_q}) begin
        trial = trial - {1'b0, radix_q};
        w[0]  = 1'b1;
      end
      rem = trial[RADIX_W-1:0];
    end
    rem_d  = rem;
    work_d = w;
  end

  assign last_step = (step_q == STEP_W'(DIV_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (ctrl_i.load) begin
      step_q <= '0;
    end else if (ctrl_i.run) begin
      step_q <= last_step ? '0 : step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      work_q  <= WORK_W'(value_i);
      rem_q   <= '0;
      radix_q <= radix_i;
    end else if (ctrl_i.run) begin
      work_q <= work_d;
      rem_q  <= last_step ? '0 : rem_d;
    end
  end

  assign stat_o.done     = ctrl_i.run & last_step;
  assign stat_o.quo_zero = (work_d == '0);
  assign stat_o.digit    = DIGIT_W'(rem_d);

endmodule

@@ sv/radix_digit_converter.sv @@
// radix_digit_converter
// input channel: in_valid_i, value_i, radix_i; a transfer happens when
// in_valid_i is high and in_stall_o is low. for a nonzero value and a
// radix of at least two, in_stall_o is high from the cycle after a transfer
// until the last digit of that value is handed to the output register.
// output channel: out_valid_o, digit_o, last_o; one transfer per digit,
// most significant first, last_o set on the least significant digit.
// a value of zero, or a radix below two, gives no output at all.
// for each value: the value is accepted, then the single divider works
// out each digit in DIV_STEPS steps (8 quotient bits per cycle over a 32 bit
// dividend), then each digit is popped from the digit stack through its
// registered read port in states ST_RD and ST_LOAD.
// the stack keeps the DIGIT_DEPTH least significant digits; further
// digits are dropped.
// out_stall_i holds the output register and pauses the stack pop; the next
// value may be taken while the final digit of the previous one still waits.
// reset empties the pipeline: no output valid, block ready for a value.
module radix_digit_converter import rdc_pkg::*; #(
  parameter int DIGIT_DEPTH = DIGIT_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [VALUE_W-1:0] value_i,
  input  logic [RADIX_W-1:0] radix_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [DIGIT_W-1:0] digit_o,
  output logic               last_o
);

  localparam int ADDR_W = $clog2(DIGIT_DEPTH);
  localparam int CNT_W  = $clog2(DIGIT_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_RD   = 4'b0100,
    ST_LOAD = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [DIGIT_W-1:0] digit_q;
  logic               last_q;

  div_ctrl_t          div_ctrl;
  div_stat_t          div_stat;

  logic               in_xfer;
  logic               push;
  logic               pop;
  logic               out_free;
  logic [ADDR_W-1:0]  raddr;
  logic [DIGIT_W-1:0] rdata;

  assign in_xfer  = in_valid_i & (state_q == ST_IDLE);
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign push     = div_stat.done & (cnt_q < CNT_W'(DIGIT_DEPTH));
  assign pop      = (state_q == ST_RD) & out_free;
  assign raddr    = ADDR_W'(cnt_q - 1'b1);

  assign div_ctrl.load = in_xfer;
  assign div_ctrl.run  = (state_q == ST_DIV);

  rdc_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (div_ctrl),
    .value_i (value_i),
    .radix_i (radix_i),
    .stat_o  (div_stat)
  );

  rdc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (DIGIT_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (div_stat.digit),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & out_stall_i;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_xfer && (value_i != '0) && (radix_i >= RADIX_W'(2))) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (push) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (div_stat.done && div_stat.quo_zero) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        if (pop) begin
          cnt_d   = cnt_q - 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        out_valid_d = 1'b1;
        state_d     = (cnt_q == '0) ? ST_IDLE : ST_RD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      digit_q <= rdata;
      last_q  <= (cnt_q == '0);
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign digit_o     = digit_q;
  assign last_o      = last_q;

endmodule
